[rtl/core/huffman_stream_decoder_core_defines.svh]
// Assertion macros shared by the decoder RTL.
`ifndef HUFFMAN_STREAM_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_STREAM_DECODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSD_ASSERT_NOW(lbl, ante, cons)
`define HSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/hsd_pkg.sv]
// Shared constants and record types of the Huffman stream decoder.
`default_nettype none
package hsd_pkg;
  localparam int MAX_SYMBOLS = 256;
  localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
  localparam int SLOT_AW     = $clog2(MAX_SYMBOLS);
  localparam int NODE_AW     = $clog2(NODE_COUNT);
  localparam int CNT_W       = SLOT_AW + 1;
  localparam int FREQ_W      = 40;
  localparam int EFREQ_W     = 32;
  localparam int COUNT_W     = 48;
  localparam int SYM_W       = 8;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [FREQ_W-1:0]  freq;
  } slot_t;

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [SYM_W-1:0]   sym;
    logic               leaf;
  } node_t;
endpackage
`default_nettype wire

[rtl/core/hsd_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/huffman_stream_decoder_core.sv]
// Top level of the Huffman stream decoder: table load, tree build and bit walk.
//
//  channel   signals                                          handshake
//  -------   -----------------------------------------------  -----------------
//  input     kind entry_symbol entry_frequency entry_last     start && !busy
//            data_byte
//  result    symbol status run_last done_res                  strobe, 1 cycle
//  config    cfg_data (symbol count)                          cfg_write
//
// A table entry without the last mark is taken while the core stays idle. The
// last entry starts the build, which repeats a scan over the n loaded slots,
// one slot RAM read a cycle, and a merge, then fetches the root record through
// S_ROOT and S_CAP. A data byte is walked with one node RAM read for each of
// its eight bits, from the accept cycle on, and a final flush of the held
// result. The walk stops early once the symbol count is reached.
// Reset is synchronous and needs no clearing pass; the slot valid bits sit in
// flip-flops. The receiver cannot stall; busy holds off new transactions.
`default_nettype none
`include "huffman_stream_decoder_core_defines.svh"
module huffman_stream_decoder_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                kind,
  input  wire logic [hsd_pkg::SYM_W-1:0]           entry_symbol,
  input  wire logic [hsd_pkg::EFREQ_W-1:0]         entry_frequency,
  input  wire logic                                entry_last,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                cfg_write,
  input  wire logic [hsd_pkg::COUNT_W-1:0]         cfg_data,
  output logic                                     strobe,
  output logic [hsd_pkg::SYM_W-1:0]                symbol,
  output logic                                     status,
  output logic                                     run_last,
  output logic                                     done_res
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MERGE, S_ROOT, S_CAP, S_WALK, S_FLUSH
  } state_t;

  state_t state;

  // Configuration and table state.
  logic [hsd_pkg::COUNT_W-1:0]     symbol_count;
  logic [hsd_pkg::MAX_SYMBOLS-1:0] slot_valid;
  logic [hsd_pkg::CNT_W-1:0]       entries_loaded;
  logic                            tree_ready;
  logic [hsd_pkg::COUNT_W-1:0]     decoded_so_far;

  // Build scan registers.
  logic [hsd_pkg::CNT_W-1:0]   scan_k;
  logic                        scan_pv;
  logic [hsd_pkg::SLOT_AW-1:0] scan_idx;
  logic                        lo_found, hi_found;
  logic [hsd_pkg::SLOT_AW-1:0] lo_idx, hi_idx;
  hsd_pkg::slot_t              lo_slot, hi_slot;
  logic [hsd_pkg::NODE_AW-1:0] next_node;
  logic [hsd_pkg::NODE_AW-1:0] root_idx;

  // Walk registers: the record of the root and of the current walk node.
  hsd_pkg::node_t   root_rec, cur_rec;
  logic [7:0]       byte_reg;
  logic [2:0]       bit_idx;
  logic             pend_valid;
  logic [hsd_pkg::SYM_W-1:0] pend_sym;
  logic             pend_done;

  // RAM ports.
  logic                        slot_we;
  logic [hsd_pkg::SLOT_AW-1:0] slot_waddr;
  hsd_pkg::slot_t              slot_wdata, slot_rdata;
  logic                        node_we;
  logic [hsd_pkg::NODE_AW-1:0] node_waddr, node_raddr;
  hsd_pkg::node_t              node_wdata, node_rdata;

  logic                        accept;
  logic [hsd_pkg::CNT_W-1:0]   load_base;
  logic                        load_ok;
  logic                        do_merge;
  logic                        hit, done_now, finish;
  logic [hsd_pkg::SYM_W-1:0]   walk_sym;
  logic [hsd_pkg::COUNT_W-1:0] cnt_inc;
  hsd_pkg::node_t              nxt_rec;
  logic                        nxt_bit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // A new table after a finished tree starts again at slot zero.
  assign load_base = tree_ready ? '0 : entries_loaded;
  assign load_ok   = load_base < hsd_pkg::CNT_W'(hsd_pkg::MAX_SYMBOLS);
  assign do_merge  = hi_found && (next_node < hsd_pkg::NODE_AW'(hsd_pkg::NODE_COUNT));

  // One bit step of the walk, fed straight from the node RAM output.
  assign hit      = root_rec.leaf || node_rdata.leaf;
  assign walk_sym = root_rec.leaf ? root_rec.sym : node_rdata.sym;
  assign cnt_inc  = decoded_so_far + hsd_pkg::COUNT_W'(1);
  assign done_now = hit && (cnt_inc >= symbol_count);
  assign finish   = done_now || (bit_idx == 3'd0);
  assign nxt_rec  = hit ? root_rec : node_rdata;
  assign nxt_bit  = byte_reg[3'(bit_idx - 3'd1)];

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = load_base[hsd_pkg::SLOT_AW-1:0];
    slot_wdata.node = hsd_pkg::NODE_AW'(load_base);
    slot_wdata.freq = hsd_pkg::FREQ_W'(entry_frequency);
    node_we    = 1'b0;
    node_waddr = hsd_pkg::NODE_AW'(load_base);
    node_wdata.left  = '0;
    node_wdata.right = '0;
    node_wdata.sym   = entry_symbol;
    node_wdata.leaf  = 1'b1;
    node_raddr = root_idx;
    case (state)
      S_IDLE: begin
        if (accept && kind == hsd_pkg::KIND_ENTRY && load_ok) begin
          slot_we = 1'b1;
          node_we = 1'b1;
        end
        node_raddr = data_byte[7] ? cur_rec.right : cur_rec.left;
      end
      S_MERGE: begin
        // Joined node takes the second slot; the lowest slot is dropped.
        slot_we         = do_merge;
        slot_waddr      = hi_idx;
        slot_wdata.node = next_node;
        slot_wdata.freq = lo_slot.freq + hi_slot.freq;
        node_we          = do_merge;
        node_waddr       = next_node;
        node_wdata.left  = lo_slot.node;
        node_wdata.right = hi_slot.node;
        node_wdata.sym   = '0;
        node_wdata.leaf  = 1'b0;
      end
      S_WALK: begin
        node_raddr = nxt_bit ? nxt_rec.right : nxt_rec.left;
      end
      default: begin
      end
    endcase
  end

  hsd_ram #(
    .WIDTH($bits(hsd_pkg::slot_t)),
    .DEPTH(hsd_pkg::MAX_SYMBOLS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (scan_k[hsd_pkg::SLOT_AW-1:0]),
    .rdata (slot_rdata)
  );

  hsd_ram #(
    .WIDTH($bits(hsd_pkg::node_t)),
    .DEPTH(hsd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      symbol_count   <= '0;
      slot_valid     <= '0;
      entries_loaded <= '0;
      tree_ready     <= 1'b0;
      decoded_so_far <= '0;
      strobe         <= 1'b0;
      pend_valid     <= 1'b0;
      scan_pv        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_write) begin
        symbol_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && kind == hsd_pkg::KIND_ENTRY) begin
            if (tree_ready) begin
              // The new table starts with only slot zero valid.
              slot_valid     <= hsd_pkg::MAX_SYMBOLS'(1);
              tree_ready     <= 1'b0;
              decoded_so_far <= '0;
            end else if (load_ok) begin
              slot_valid[load_base[hsd_pkg::SLOT_AW-1:0]] <= 1'b1;
            end
            if (load_ok) begin
              entries_loaded <= load_base + hsd_pkg::CNT_W'(1);
              next_node      <= hsd_pkg::NODE_AW'(load_base + hsd_pkg::CNT_W'(1));
            end else begin
              entries_loaded <= load_base;
              next_node      <= hsd_pkg::NODE_AW'(load_base);
            end
            if (entry_last) begin
              scan_k   <= '0;
              scan_pv  <= 1'b0;
              lo_found <= 1'b0;
              hi_found <= 1'b0;
              state    <= S_SCAN;
            end
          end else if (accept) begin
            if (!tree_ready) begin
              strobe   <= 1'b1;
              symbol   <= '0;
              status   <= 1'b1;
              run_last <= 1'b1;
              done_res <= 1'b0;
            end else if (decoded_so_far < symbol_count) begin
              byte_reg   <= data_byte;
              bit_idx    <= 3'd7;
              pend_valid <= 1'b0;
              state      <= S_WALK;
            end
          end
        end
        S_SCAN: begin
          // Strict compares keep the earliest slot on equal frequencies.
          if (scan_pv && slot_valid[scan_idx]) begin
            if (!lo_found || slot_rdata.freq < lo_slot.freq) begin
              hi_found <= lo_found;
              hi_idx   <= lo_idx;
              hi_slot  <= lo_slot;
              lo_found <= 1'b1;
              lo_idx   <= scan_idx;
              lo_slot  <= slot_rdata;
            end else if (!hi_found || slot_rdata.freq < hi_slot.freq) begin
              hi_found <= 1'b1;
              hi_idx   <= scan_idx;
              hi_slot  <= slot_rdata;
            end
          end
          scan_pv  <= scan_k < entries_loaded;
          scan_idx <= scan_k[hsd_pkg::SLOT_AW-1:0];
          if (scan_k < entries_loaded) begin
            scan_k <= scan_k + hsd_pkg::CNT_W'(1);
          end else if (!scan_pv) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (do_merge) begin
            slot_valid[lo_idx] <= 1'b0;
            next_node <= next_node + hsd_pkg::NODE_AW'(1);
            scan_k    <= '0;
            scan_pv   <= 1'b0;
            lo_found  <= 1'b0;
            hi_found  <= 1'b0;
            state     <= S_SCAN;
          end else begin
            root_idx <= (lo_slot.node < hsd_pkg::NODE_AW'(hsd_pkg::NODE_COUNT)) ?
                        lo_slot.node : '0;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          state <= S_CAP;
        end
        S_CAP: begin
          root_rec   <= node_rdata;
          cur_rec    <= node_rdata;
          tree_ready <= 1'b1;
          state      <= S_IDLE;
        end
        S_WALK: begin
          // Each new symbol pushes out the held one; the last waits for flush.
          if (hit) begin
            decoded_so_far <= cnt_inc;
            if (pend_valid) begin
              strobe   <= 1'b1;
              symbol   <= pend_sym;
              status   <= 1'b0;
              run_last <= 1'b0;
              done_res <= pend_done;
            end
            pend_valid <= 1'b1;
            pend_sym   <= walk_sym;
            pend_done  <= done_now;
          end
          cur_rec <= nxt_rec;
          bit_idx <= bit_idx - 3'd1;
          if (finish) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend_valid) begin
            strobe   <= 1'b1;
            symbol   <= pend_sym;
            status   <= 1'b0;
            run_last <= 1'b1;
            done_res <= pend_done;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HSD_ASSERT_NOW(a_err_is_last, strobe && status, run_last && !done_res)
  `HSD_ASSERT_NOW(a_done_is_last, strobe && done_res, run_last)
  `HSD_ASSERT_NEXT(a_no_tree_err, accept && kind == hsd_pkg::KIND_DATA && !tree_ready, strobe && status)
  `HSD_ASSERT_NEXT(a_flush_ends, state == S_FLUSH, state == S_IDLE && !pend_valid)
endmodule
`default_nettype wire
